// ===== sv/csu_pkg.sv =====
// ----------------------------------------------------------------------------
// Counting semaphore unit package
// Sizes, field widths, operation and status codes shared by the block.
// ----------------------------------------------------------------------------
package csu_pkg;

   localparam int MAX_PROCS = 16;
   localparam int NUM_SEMS  = 16;

   localparam int OP_W      = 2;
   localparam int SEMF_W    = 4;
   localparam int PID_W     = 4;
   localparam int CNT_W     = 8;
   localparam int STATUS_W  = 3;

   localparam int SEM_IDX_W = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
   localparam int SLOT_W    = $clog2(MAX_PROCS);
   localparam int WFILL_W   = $clog2(MAX_PROCS + 1);
   localparam int PFILL_W   = $clog2(NUM_SEMS + 1);
   localparam int WDEPTH    = NUM_SEMS * MAX_PROCS;
   localparam int WADDR_W   = $clog2(WDEPTH);

   localparam logic [OP_W-1:0] OP_INIT = 2'd0;
   localparam logic [OP_W-1:0] OP_WAIT = 2'd1;
   localparam logic [OP_W-1:0] OP_POST = 2'd2;

   localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE    = 3'd0,
      ST_BLOCKED = 3'd1,
      ST_WOKEN   = 3'd2,
      ST_NOFREE  = 3'd3,
      ST_QFULL   = 3'd4
   } status_type;

endpackage

// ===== sv/csu_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module csu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic                                      rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/counting_semaphore_unit.sv =====
// A request is held in the request register, then its result in the response register.
// Throughput: one operation per cycle while rsp_tready does not stall the response; the state tables
// are read and written in the single stage between the request and response registers.
// Reset clears the request and response stages and all per-semaphore counts, queue heads and fill
// levels, and fills the free-id counter to the pool size; waiter RAM needs no clear.
// ----------------------------------------------------------------------------
// Counting semaphore unit
// Allocates semaphore ids and runs wait and post with a FIFO of waiters
// per semaphore.
// ----------------------------------------------------------------------------
module counting_semaphore_unit
   import csu_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // sem_index[3:0], proc_id[7:4], initial_count[15:8]
   input  logic [1:0]  req_tuser,   // op[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // new_sem_index[3:0], woken_proc[7:4], count_after[15:8]
   output logic [2:0]  rsp_tuser    // status[2:0]
);

   logic                  in_valid_ff, in_valid_in;
   logic [OP_W-1:0]       in_op_ff;
   logic [SEMF_W-1:0]     in_sem_ff;
   logic [PID_W-1:0]      in_pid_ff;
   logic [CNT_W-1:0]      in_cnt_ff;

   logic                  res_valid_ff, res_valid_in;
   status_type            res_status_ff, res_status_in;
   logic [SEMF_W-1:0]     res_sem_ff, res_sem_in;
   logic [CNT_W-1:0]      res_cnt_ff, res_cnt_in;

   logic [SEM_IDX_W-1:0]  pool_head_ff, pool_head_in;
   logic [PFILL_W-1:0]    pool_fill_ff, pool_fill_in;
   logic [CNT_W-1:0]      pass_ff  [NUM_SEMS];
   logic [CNT_W-1:0]      pass_in  [NUM_SEMS];
   logic [SLOT_W-1:0]     whead_ff [NUM_SEMS];
   logic [SLOT_W-1:0]     whead_in [NUM_SEMS];
   logic [WFILL_W-1:0]    wfill_ff [NUM_SEMS];
   logic [WFILL_W-1:0]    wfill_in [NUM_SEMS];

   logic                  req_fire, fire;
   logic                  in_range;
   logic [SEM_IDX_W-1:0]  idx;
   logic [CNT_W-1:0]      cnt_rd;
   logic [SLOT_W-1:0]     head_rd, head_next, tail_slot;
   logic [WFILL_W-1:0]    wfill_rd;
   logic [SLOT_W:0]       tail_sum;
   logic [WADDR_W-1:0]    wbase;
   logic                  wr_en;
   logic [WADDR_W-1:0]    wr_addr, rd_addr;
   logic [PID_W-1:0]      rd_data;

   assign fire       = in_valid_ff && (!res_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || fire;
   assign req_fire   = req_tvalid && req_tready;

   assign in_valid_in  = req_fire ? 1'b1 : (fire ? 1'b0 : in_valid_ff);
   assign res_valid_in = fire ? 1'b1 : (rsp_tready ? 1'b0 : res_valid_ff);

   assign in_range  = (32'(in_sem_ff) < NUM_SEMS);
   assign idx       = SEM_IDX_W'(in_sem_ff);
   assign cnt_rd    = pass_ff[idx];
   assign head_rd   = whead_ff[idx];
   assign wfill_rd  = wfill_ff[idx];
   assign head_next = (32'(head_rd) == MAX_PROCS - 1) ? '0 : head_rd + 1'b1;
   assign tail_sum  = (SLOT_W + 1)'(head_rd) + (SLOT_W + 1)'(wfill_rd);
   assign tail_slot = (32'(tail_sum) >= MAX_PROCS)
                      ? SLOT_W'(tail_sum - (SLOT_W + 1)'(MAX_PROCS))
                      : SLOT_W'(tail_sum);
   assign wbase     = WADDR_W'(idx) * WADDR_W'(MAX_PROCS);
   assign wr_addr   = wbase + WADDR_W'(tail_slot);
   assign rd_addr   = wbase + WADDR_W'(head_rd);

   always_comb begin
      pool_head_in  = pool_head_ff;
      pool_fill_in  = pool_fill_ff;
      pass_in       = pass_ff;
      whead_in      = whead_ff;
      wfill_in      = wfill_ff;
      res_status_in = ST_DONE;
      res_sem_in    = '0;
      res_cnt_in    = '0;
      wr_en         = 1'b0;
      case (in_op_ff)
         OP_INIT: begin
            if (pool_fill_ff == '0) begin
               res_status_in = ST_NOFREE;
            end else begin
               pool_head_in = (32'(pool_head_ff) == NUM_SEMS - 1) ? '0
                              : pool_head_ff + 1'b1;
               pool_fill_in = pool_fill_ff - 1'b1;
               pass_in[pool_head_ff]  = in_cnt_ff;
               whead_in[pool_head_ff] = '0;
               wfill_in[pool_head_ff] = '0;
               res_sem_in = SEMF_W'(pool_head_ff);
               res_cnt_in = in_cnt_ff;
            end
         end
         OP_WAIT: begin
            if (in_range) begin
               if (cnt_rd != '0) begin
                  pass_in[idx] = cnt_rd - 1'b1;
                  res_cnt_in   = cnt_rd - 1'b1;
               end else if (32'(wfill_rd) >= MAX_PROCS) begin
                  res_status_in = ST_QFULL;
               end else begin
                  wr_en         = fire;
                  wfill_in[idx] = wfill_rd + 1'b1;
                  res_status_in = ST_BLOCKED;
               end
            end
         end
         OP_POST: begin
            if (in_range) begin
               if (wfill_rd != '0) begin
                  whead_in[idx] = head_next;
                  wfill_in[idx] = wfill_rd - 1'b1;
                  res_status_in = ST_WOKEN;
                  res_cnt_in    = cnt_rd;
               end else if (cnt_rd != CNT_MAX) begin
                  pass_in[idx] = cnt_rd + 1'b1;
                  res_cnt_in   = cnt_rd + 1'b1;
               end else begin
                  res_cnt_in = cnt_rd;
               end
            end
         end
         default: begin
            res_status_in = ST_DONE;
         end
      endcase
   end

   csu_ram #(
      .WIDTH (PID_W),
      .DEPTH (WDEPTH)
   ) u_waiters (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (in_pid_ff),
      .rd_en   (fire),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         res_valid_ff <= 1'b0;
         pool_head_ff <= '0;
         pool_fill_ff <= PFILL_W'(NUM_SEMS);
         for (int i = 0; i < NUM_SEMS; i++) begin
            pass_ff[i]  <= '0;
            whead_ff[i] <= '0;
            wfill_ff[i] <= '0;
         end
      end else begin
         in_valid_ff  <= in_valid_in;
         res_valid_ff <= res_valid_in;
         if (fire) begin
            pool_head_ff <= pool_head_in;
            pool_fill_ff <= pool_fill_in;
            pass_ff      <= pass_in;
            whead_ff     <= whead_in;
            wfill_ff     <= wfill_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_sem_ff <= req_tdata[3:0];
         in_pid_ff <= req_tdata[7:4];
         in_cnt_ff <= req_tdata[15:8];
         in_op_ff  <= req_tuser;
      end
      if (fire) begin
         res_status_ff <= res_status_in;
         res_sem_ff    <= res_sem_in;
         res_cnt_ff    <= res_cnt_in;
      end
   end

   assign rsp_tvalid      = res_valid_ff;
   assign rsp_tuser       = res_status_ff;
   assign rsp_tdata[3:0]  = res_sem_ff;
   assign rsp_tdata[7:4]  = (res_status_ff == ST_WOKEN) ? rd_data : '0;
   assign rsp_tdata[15:8] = res_cnt_ff;

   a_pool_fill_bound: assert property (@(posedge clock) disable iff (reset)
      32'(pool_fill_ff) <= NUM_SEMS)
      else $error("free id count above pool size");

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && in_range |-> 32'(wfill_rd) <= MAX_PROCS)
      else $error("wait queue fill above capacity");

   a_block_enqueues: assert property (@(posedge clock) disable iff (reset)
      fire && res_status_in == ST_BLOCKED |=>
      wfill_ff[$past(idx)] == $past(wfill_rd) + 1'b1)
      else $error("blocked wait did not grow its queue");

   a_init_takes_id: assert property (@(posedge clock) disable iff (reset)
      fire && in_op_ff == OP_INIT && pool_fill_ff != '0 |=>
      pool_fill_ff == $past(pool_fill_ff) - 1'b1)
      else $error("init did not consume a free id");

   a_nofree_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == ST_NOFREE |-> rsp_tdata == '0)
      else $error("no-free response carries data");

endmodule
